FILE: sv/bfs_pkg.sv
`timescale 1ns / 1ps
package bfs_pkg;
  localparam int unsigned SYMBOLS    = 256;
  localparam int unsigned SYM_W      = $clog2(SYMBOLS);
  localparam int unsigned COUNT_BITS = 32;
  localparam int unsigned OUT_BITS   = 32;

  typedef enum logic [1:0] {
    OP_COUNT = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] data_byte;
    logic [7:0] rank;
  } in_item_t;

  typedef struct packed {
    logic [7:0]          symbol;
    logic [OUT_BITS-1:0] occurrences;
    logic                saturated;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CNT_RD,
    ST_CNT_WR,
    ST_CLR,
    ST_SRT_RDS,
    ST_SRT_RDT,
    ST_SRT_CMP,
    ST_SRT_WR,
    ST_RD_SYM,
    ST_RD_CNT,
    ST_OUT
  } state_e;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
endpackage

FILE: sv/bfs_rank_cmp.sv
`timescale 1ns / 1ps
module bfs_rank_cmp
  import bfs_pkg::*;
(
  input  logic [COUNT_BITS-1:0] c_i,
  input  logic [COUNT_BITS-1:0] d_i,
  input  logic [SYM_W-1:0]      s_i,
  input  logic [SYM_W-1:0]      t_i,
  output logic                  before_o
);
  // t sorts ahead of s
  assign before_o = (d_i < c_i) || ((d_i == c_i) && (t_i < s_i));
endmodule

FILE: sv/byte_frequency_sort.sv
`timescale 1ns / 1ps
// a read rebuilds the sorted order first when a count changed or a clear ran
// since the last sort; otherwise it reads the current order directly
// one transaction at a time; the rebuild does its compares one after another on the
// counter memory read port and one shared comparator
// reset: counts cleared by a sweep over all 256 entries after reset, order marked stale
module byte_frequency_sort
  import bfs_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);
  // counter memory, one read port and one write port, registered read
  logic [COUNT_BITS-1:0] cnt_mem [SYMBOLS];
  logic [SYM_W-1:0]      sorted_mem [SYMBOLS];

  state_e                state_q, state_d;
  in_item_t              item_q, item_d;
  logic [SYM_W-1:0]      s_q, s_d, t_q, t_d, pos_q, pos_d, clr_q, clr_d;
  logic                  stale_q, stale_d;
  logic [COUNT_BITS-1:0] c_q, c_d;
  out_item_t             res_q, res_d;

  logic                  cnt_we, srt_we;
  logic [SYM_W-1:0]      cnt_addr, cnt_waddr, srt_addr;
  logic [COUNT_BITS-1:0] cnt_wdata, cnt_rdata;
  logic [SYM_W-1:0]      srt_rdata;
  logic                  t_ahead;

  always_ff @(posedge clk_i) begin
    if (cnt_we) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
    end
    cnt_rdata <= cnt_mem[cnt_addr];
  end

  always_ff @(posedge clk_i) begin
    if (srt_we) begin
      sorted_mem[pos_q] <= s_q;
    end
    srt_rdata <= sorted_mem[srt_addr];
  end

  // the one shared comparator of the rebuild
  bfs_rank_cmp u_cmp (
    .c_i      (c_q),
    .d_i      (cnt_rdata),
    .s_i      (s_q),
    .t_i      (t_q),
    .before_o (t_ahead)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLR;
      stale_q <= 1'b1;
      clr_q   <= '0;
      s_q     <= '0;
      t_q     <= '0;
      pos_q   <= '0;
    end else begin
      state_q <= state_d;
      stale_q <= stale_d;
      clr_q   <= clr_d;
      s_q     <= s_d;
      t_q     <= t_d;
      pos_q   <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    c_q    <= c_d;
    res_q  <= res_d;
  end

  always_comb begin
    state_d     = state_q;
    stale_d     = stale_q;
    clr_d       = clr_q;
    s_d         = s_q;
    t_d         = t_q;
    pos_d       = pos_q;
    item_d      = item_q;
    c_d         = c_q;
    res_d       = res_q;
    cnt_we      = 1'b0;
    cnt_waddr   = item_q.data_byte;
    cnt_wdata   = cnt_rdata + COUNT_BITS'(1);
    cnt_addr    = item_q.data_byte;
    srt_we      = 1'b0;
    srt_addr    = item_q.rank;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cnt_addr   = in_data_i.data_byte;
        if (in_valid_i) begin
          item_d = in_data_i;
          unique case (op_e'(in_data_i.operation))
            OP_COUNT: state_d = ST_CNT_RD;
            OP_CLEAR: begin
              clr_d   = '0;
              stale_d = 1'b1;
              state_d = ST_CLR;
            end
            OP_READ: begin
              if (stale_q) begin
                s_d     = '0;
                state_d = ST_SRT_RDS;
              end else begin
                state_d = ST_RD_SYM;
              end
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_CNT_RD: state_d = ST_CNT_WR; // read data lands
      ST_CNT_WR: begin
        if (cnt_rdata != COUNT_MAX) begin
          cnt_we  = 1'b1;
          stale_d = 1'b1;
        end
        state_d = ST_IDLE;
      end
      ST_CLR: begin
        cnt_we    = 1'b1;
        cnt_waddr = clr_q;
        cnt_wdata = '0;
        clr_d     = clr_q + SYM_W'(1);
        if (clr_q == SYM_W'(SYMBOLS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      // rebuild: fetch count of s, then scan every t
      ST_SRT_RDS: begin
        cnt_addr = s_q;
        t_d      = '0;
        pos_d    = '0;
        state_d  = ST_SRT_RDT;
      end
      ST_SRT_RDT: begin
        cnt_addr = t_q;
        if (t_q == '0) begin
          c_d = cnt_rdata;
        end
        state_d = ST_SRT_CMP;
      end
      ST_SRT_CMP: begin
        cnt_addr = t_q;
        if (t_ahead) begin
          pos_d = pos_q + SYM_W'(1);
        end
        t_d = t_q + SYM_W'(1);
        if (t_q == SYM_W'(SYMBOLS - 1)) begin
          state_d = ST_SRT_WR;
        end else begin
          state_d = ST_SRT_RDT;
        end
      end
      ST_SRT_WR: begin
        srt_we = 1'b1;
        s_d    = s_q + SYM_W'(1);
        if (s_q == SYM_W'(SYMBOLS - 1)) begin
          stale_d = 1'b0;
          state_d = ST_RD_SYM;
        end else begin
          state_d = ST_SRT_RDS;
        end
      end
      ST_RD_SYM: state_d = ST_RD_CNT; // sorted entry read lands next cycle
      ST_RD_CNT: begin
        cnt_addr = srt_rdata;
        res_d.symbol = srt_rdata;
        state_d  = ST_OUT;
      end
      ST_OUT: begin
        cnt_addr    = res_q.symbol;
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // result fields from the registered count read
  always_comb begin
    out_data_o             = res_q;
    out_data_o.occurrences = cnt_rdata[OUT_BITS-1:0];
    out_data_o.saturated   = (cnt_rdata == COUNT_MAX);
  end
endmodule

FILE: sim/byte_frequency_sort_tb.sv
`timescale 1ns / 1ps
module byte_frequency_sort_tb;
  import bfs_pkg::*;

  typedef struct {
    in_item_t  item;
    bit        given;  // expected read result typed in below
    out_item_t known;
  } stim_row_t;

  typedef struct {
    bit        given;
    out_item_t known;
  } read_note_t;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_ready_o;
  in_item_t  in_data_i;
  logic      out_valid_o;
  logic      out_ready_i;
  out_item_t out_data_o;

  byte_frequency_sort DUT (.*);

  // model of the histogram and its ascending stable order
  logic [COUNT_BITS-1:0] hist_count [SYMBOLS];
  logic [7:0]            rank_symbol [SYMBOLS];
  bit                    order_dirty;

  out_item_t  pending_results [$];
  read_note_t read_notes [$];
  int         fail_cnt;
  int         read_cnt;
  int         count_cnt;
  int         idle_mode;  // 0 none, 1 sender gaps, 2 receiver stalls, 3 both

  stim_row_t  directed [] = '{
    '{'{OP_READ,  8'h00, 8'd0},   1, '{8'd0,   32'd0, 1'b0}},
    '{'{OP_READ,  8'h5a, 8'd255}, 1, '{8'd255, 32'd0, 1'b0}},
    '{'{OP_COUNT, 8'hff, 8'd0},   0, '{8'd0,   32'd0, 1'b0}},
    '{'{OP_COUNT, 8'hff, 8'd255}, 0, '{8'd0,   32'd0, 1'b0}},
    '{'{OP_COUNT, 8'h00, 8'd0},   0, '{8'd0,   32'd0, 1'b0}},
    '{'{OP_NONE,  8'haa, 8'd55},  0, '{8'd0,   32'd0, 1'b0}},
    '{'{OP_READ,  8'h00, 8'd255}, 1, '{8'd255, 32'd2, 1'b0}},
    '{'{OP_READ,  8'h00, 8'd254}, 1, '{8'd0,   32'd1, 1'b0}},
    '{'{OP_READ,  8'hff, 8'd0},   1, '{8'd1,   32'd0, 1'b0}},
    '{'{OP_READ,  8'h00, 8'd128}, 0, '{8'd0,   32'd0, 1'b0}},
    '{'{OP_CLEAR, 8'h33, 8'd7},   0, '{8'd0,   32'd0, 1'b0}},
    '{'{OP_COUNT, 8'h80, 8'd0},   0, '{8'd0,   32'd0, 1'b0}}
  };

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // stable ascending placement, ties kept in byte order
  function automatic void sort_histogram();
    int unsigned pos;
    for (int s = 0; s < SYMBOLS; s++) begin
      pos = 0;
      for (int t = 0; t < SYMBOLS; t++) begin
        if (hist_count[t] < hist_count[s] || (hist_count[t] == hist_count[s] && t < s))
          pos++;
      end
      rank_symbol[pos] = s[7:0];
    end
    order_dirty = 1'b0;
  endfunction

  function automatic void apply_transaction(in_item_t it, output bit has_res,
                                            output out_item_t res);
    logic [7:0] sym;
    has_res = 1'b0;
    res = '0;
    case (op_e'(it.operation))
      OP_COUNT: begin
        if (hist_count[it.data_byte] != COUNT_MAX) begin
          hist_count[it.data_byte]++;
          order_dirty = 1'b1;
        end
      end
      OP_CLEAR: begin
        foreach (hist_count[i]) hist_count[i] = '0;
        order_dirty = 1'b1;
      end
      OP_READ: begin
        if (order_dirty) sort_histogram();
        sym = rank_symbol[it.rank];
        res.symbol      = sym;
        res.occurrences = hist_count[sym];
        res.saturated   = (hist_count[sym] == COUNT_MAX);
        has_res = 1'b1;
      end
      default: ;
    endcase
  endfunction

  // input side monitor: predict on every accepted transaction
  always @(posedge clk_i) begin
    bit         has_res;
    out_item_t  res;
    read_note_t note;
    if (rst_ni && in_valid_i && in_ready_o) begin
      apply_transaction(in_data_i, has_res, res);
      if (has_res) begin
        note = read_notes.pop_front();
        pending_results.push_back(note.given ? note.known : res);
      end
    end
  end

  // output side monitor
  always @(posedge clk_i) begin
    out_item_t exp_res;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result %p", $time, out_data_o);
        fail_cnt++;
      end else begin
        exp_res = pending_results.pop_front();
        if (out_data_o.symbol !== exp_res.symbol) begin
          $display("%0t: symbol expected %0d actual %0d", $time, exp_res.symbol,
                   out_data_o.symbol);
          fail_cnt++;
        end
        if (out_data_o.occurrences !== exp_res.occurrences) begin
          $display("%0t: occurrences expected %0d actual %0d", $time,
                   exp_res.occurrences, out_data_o.occurrences);
          fail_cnt++;
        end
        if (out_data_o.saturated !== exp_res.saturated) begin
          $display("%0t: saturated expected %0b actual %0b", $time,
                   exp_res.saturated, out_data_o.saturated);
          fail_cnt++;
        end
      end
    end
  end

  // receiver back-pressure
  always @(posedge clk_i) begin
    if (idle_mode == 3)     out_ready_i <= ($urandom_range(0, 99) >= 36);
    else if (idle_mode == 2) out_ready_i <= ($urandom_range(0, 99) >= 59);
    else                    out_ready_i <= 1'b1;
  end

  task automatic send_item(in_item_t it, bit given, out_item_t known);
    read_note_t note;
    int         gap_pct;
    gap_pct = (idle_mode == 3) ? 36 : 59;
    if (it.operation == OP_READ) begin
      note.given = given;
      note.known = known;
      read_notes.push_back(note);
      read_cnt++;
    end
    if (it.operation == OP_COUNT) count_cnt++;
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
    if (idle_mode == 1 || idle_mode == 3) begin
      while ($urandom_range(0, 99) < gap_pct) begin
        in_valid_i <= 1'b0;
        in_data_i  <= in_item_t'($urandom);
        @(posedge clk_i);
      end
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0 || read_notes.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    in_item_t it;
    int       hot_hi;
    fail_cnt    = 0;
    read_cnt    = 0;
    count_cnt   = 0;
    idle_mode   = 0;
    order_dirty = 1'b1;
    foreach (hist_count[i]) hist_count[i] = '0;
    foreach (rank_symbol[i]) rank_symbol[i] = '0;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    out_ready_i = 1'b1;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed rows: reset state, extremes, ignored op, clear
    foreach (directed[i]) send_item(directed[i].item, directed[i].given, directed[i].known);
    drain();

    // random phases: a burst of counts, then a burst of reads on one sorted order
    // so the slow rebuild runs once per phase
    for (int ph = 0; ph < 4; ph++) begin
      idle_mode = ph;
      hot_hi = (ph == 2) ? 255 : 15;
      for (int n = 0; n < 450; n++) begin
        it.rank = 8'($urandom);
        if ($urandom_range(0, 19) == 0) begin
          it.operation = OP_NONE;
          it.data_byte = 8'($urandom);
        end else begin
          it.operation = OP_COUNT;
          it.data_byte = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                     : 8'($urandom_range(0, hot_hi));
        end
        send_item(it, 1'b0, '0);
      end
      for (int n = 0; n < 50; n++) begin
        it.operation = OP_READ;
        it.data_byte = 8'($urandom);
        case ($urandom_range(0, 7))
          0:       it.rank = 8'd0;
          1:       it.rank = 8'd255;
          default: it.rank = 8'($urandom);
        endcase
        send_item(it, 1'b0, '0);
      end
      // hold off until every result of this phase is back
      drain();
      if (ph == 1) send_item('{OP_CLEAR, 8'h00, 8'h00}, 1'b0, '0);
    end

    drain();
    repeat (20) @(posedge clk_i);
    $display("covered %0d counted bytes and %0d rank reads over four idling phases,",
             count_cnt, read_cnt);
    $display("including reads at reset, after a clear and at both rank extremes");
    if (fail_cnt == 0) begin
      $display("byte_frequency_sort: match");
    end else begin
      $display("byte_frequency_sort: mismatch");
    end
    $finish;
  end

  // the run holds six rebuilds; they plus stalls fit well inside this timeout
  initial begin
    #60ms;
    $display("byte_frequency_sort: mismatch");
    $finish;
  end

endmodule
